>>> hw/rtl/sdf_pkg.sv
// shared types and constants for the swept delay flanger
`timescale 1ns / 1ps

package sdf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;

  // gain register after reset, about 0.7 in q15
  localparam gain_t GAIN_RESET = 15'd22938;

  // fixed-point constants for the offset table, q30
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

endpackage

>>> hw/rtl/sdf_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module sdf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 81
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first: a read and a write to one address in one cycle return the old data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sdf_sweep.sv
// lfo phase and swept delay offset, next offset counted against a threshold table
`timescale 1ns / 1ps

module sdf_sweep #(
  parameter int unsigned DELAY_SPAN = 80,
  parameter int unsigned LFO_STEPS  = 8000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  output logic [$clog2(DELAY_SPAN+1)-1:0]   offset_o
);

  localparam int unsigned PH_W   = $clog2(LFO_STEPS);
  localparam int unsigned HALF   = LFO_STEPS / 2;
  localparam int unsigned FOLD_W = $clog2(HALF + 2);
  localparam int unsigned D_W    = $clog2(DELAY_SPAN + 1);
  localparam int unsigned IDX_W  = $clog2(DELAY_SPAN);

  localparam longint unsigned LfoL = 64'(LFO_STEPS);
  localparam longint          OneS = sdf_pkg::ONE_Q30;

  // 1 - cos(2 pi p / steps) in q30, truncating taylor series to the x^24 term
  function automatic longint omc_q30(input longint unsigned pin);
    longint unsigned pp, m, mm, x, x2, term;
    longint          sum, omc;
    logic            flip;
    pp = pin;
    if (pp > LfoL - pp) pp = LfoL - pp;
    m = 2 * pp;
    if (m == 0) return 0;
    if (3 * m == LfoL) return OneS / 2;
    if (2 * m == LfoL) return OneS;
    if (3 * m == 2 * LfoL) return 3 * (OneS / 2);
    if (m == LfoL) return 2 * OneS;
    flip = (2 * m > LfoL);
    mm   = flip ? (LfoL - m) : m;
    x    = (sdf_pkg::PI_Q30 * mm + LfoL / 2) / LfoL;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = 64'(OneS);
    sum  = OneS;
    term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 306; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 380; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 462; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 552; sum = sum + longint'(term);
    omc = flip ? (OneS + sum) : (OneS - sum);
    if (omc < 0) omc = 0;
    if (omc > 2 * OneS) omc = 2 * OneS;
    return omc;
  endfunction

  function automatic longint unsigned offset_of(input longint unsigned pp);
    longint unsigned v;
    v = (64'(DELAY_SPAN) * 64'(omc_q30(pp))) >> 31;
    if (v > 64'(DELAY_SPAN)) v = 64'(DELAY_SPAN);
    return v;
  endfunction

  // entry k-1 is the smallest folded phase whose offset reaches k
  function automatic logic [DELAY_SPAN*FOLD_W-1:0] thr_table();
    logic [DELAY_SPAN*FOLD_W-1:0] tab;
    int unsigned                  filled;
    longint unsigned              dv;
    for (int unsigned i = 0; i < DELAY_SPAN; i++) begin
      tab[i*FOLD_W +: FOLD_W] = FOLD_W'(HALF + 1);
    end
    filled = 0;
    for (int unsigned pp = 0; pp <= HALF; pp++) begin
      dv = offset_of(64'(pp));
      while (64'(filled) < dv) begin
        tab[filled*FOLD_W +: FOLD_W] = FOLD_W'(pp);
        filled++;
      end
    end
    return tab;
  endfunction

  localparam logic [DELAY_SPAN*FOLD_W-1:0] THR = thr_table();

  logic [PH_W-1:0]   phase_q, phase_nx;
  logic [PH_W:0]     tail;
  logic [FOLD_W-1:0] fold, thr;
  logic [D_W-1:0]    d_q, acc_q, k_q;
  logic [IDX_W-1:0]  idx;
  logic              busy;

  assign phase_nx = (phase_q == PH_W'(LFO_STEPS - 1)) ? '0 : phase_q + 1'b1;
  assign tail     = (PH_W+1)'(LFO_STEPS) - {1'b0, phase_nx};
  assign fold     = ({1'b0, phase_nx} > tail) ? FOLD_W'(tail) : FOLD_W'(phase_nx);

  assign busy = (k_q != D_W'(DELAY_SPAN));
  assign idx  = busy ? k_q[IDX_W-1:0] : '0;
  assign thr  = THR[idx*FOLD_W +: FOLD_W];

  // one threshold compared per cycle, the count ending just before the earliest
  // next phase step, which needs span + 1 pointer advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      d_q     <= '0;
      acc_q   <= '0;
      k_q     <= '0;
    end else if (step_i) begin
      phase_q <= phase_nx;
      d_q     <= acc_q;
      acc_q   <= '0;
      k_q     <= '0;
    end else if (busy) begin
      acc_q <= acc_q + D_W'(fold >= thr);
      k_q   <= k_q + 1'b1;
    end
  end

  assign offset_o = d_q;

`ifndef ASSERT_OFF
  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> !busy) else $error("phase step before offset count finished");
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> d_q <= D_W'(DELAY_SPAN)) else $error("offset beyond span");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> (phase_q == 0 || phase_q == $past(phase_q) + 1'b1))
    else $error("phase did not advance by one");
`endif

endmodule

>>> hw/rtl/swept_delay_flanger.sv
// swept delay flanger top: delay store, read pointer, gain and output datapath
// results pass through stage one and then the output register; one item per cycle sustained while out_ready_i is high
// the delay store is a ram with registered read, written and read once per transfer
// reset: pointer, phase and offset to zero, gain to 22938; store entries read as zero
// until written (one valid flop per entry, no clearing pass)
`timescale 1ns / 1ps

module swept_delay_flanger #(
  parameter int unsigned DELAY_SPAN = 80,
  parameter int unsigned LFO_STEPS  = 8000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: gain register
  input  logic              cfg_we_i,
  input  sdf_pkg::gain_t    cfg_wdata_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sdf_pkg::sample_t  sample_in_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sdf_pkg::sample_t  sample_out_o
);

  localparam int unsigned DEPTH = DELAY_SPAN + 1;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  // ---------------------------------------------------------------------------
  // handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic accept, out_load;
  logic st_vld_q, out_vld_q;

  // output register loads when empty or being taken
  assign out_load   = !out_vld_q || out_ready_i;
  // input stage can take a transfer when it is empty or moving on
  assign in_ready_o = !st_vld_q || out_load;
  assign accept     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // gain register
  // ---------------------------------------------------------------------------
  sdf_pkg::gain_t gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= sdf_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // read pointer and write slot
  // ---------------------------------------------------------------------------
  logic [PTR_W-1:0] ptr_q, offset, slot;
  logic             ptr_last;

  assign ptr_last = (ptr_q == PTR_W'(DELAY_SPAN));

  // slot sits offset places behind the pointer, wrapping around the store
  assign slot = (ptr_q >= offset) ? (ptr_q - offset)
              : PTR_W'({1'b0, ptr_q} + (PTR_W+1)'(DEPTH) - {1'b0, offset});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (accept) begin
      ptr_q <= ptr_last ? '0 : ptr_q + 1'b1;
    end
  end

  // lfo phase advances when the pointer wraps
  sdf_sweep #(
    .DELAY_SPAN (DELAY_SPAN),
    .LFO_STEPS  (LFO_STEPS)
  ) u_sweep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept && ptr_last),
    .offset_o (offset)
  );

  // ---------------------------------------------------------------------------
  // delay store: read at the pointer and write at the slot on the same edge
  // ---------------------------------------------------------------------------
  sdf_pkg::sample_t rd_data;
  logic [DEPTH-1:0] vld_q;

  sdf_ram #(
    .Width (sdf_pkg::SAMPLE_W),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (slot),
    .wdata_i (sample_in_i),
    .re_i    (accept),
    .raddr_i (ptr_q),
    .rdata_o (rd_data)
  );

  // entry written at least once since reset; unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (accept) begin
      vld_q[slot] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stage one: sample and hit flag beside the ram read data
  // ---------------------------------------------------------------------------
  sdf_pkg::sample_t st_smp_q;
  logic             st_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      st_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_smp_q <= sample_in_i;
      st_hit_q <= vld_q[ptr_q];
    end
  end

  // ---------------------------------------------------------------------------
  // mix: sample + round(gain * delayed / 2^15), saturated to 16 bits
  // ---------------------------------------------------------------------------
  sdf_pkg::sample_t   delayed, y_sat;
  logic signed [31:0] prod, rnd;
  logic signed [16:0] scaled;
  logic signed [17:0] y;

  assign delayed = st_hit_q ? rd_data : '0;
  assign prod    = $signed({1'b0, gain_q}) * delayed;
  // adding half an lsb then an arithmetic shift rounds halves up
  assign rnd     = prod + 32'sd16384;
  assign scaled  = rnd[31:15];
  assign y       = {{2{st_smp_q[15]}}, st_smp_q} + {scaled[16], scaled};

  always_comb begin
    if (y > 18'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y < -18'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  sdf_pkg::sample_t out_smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= st_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && st_vld_q) begin
      out_smp_q <= y_sat;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sample_out_o = out_smp_q;

`ifndef ASSERT_OFF
  a_ptr_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ptr_last |=> ptr_q == '0) else $error("pointer did not wrap");
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !ptr_last |=> ptr_q == $past(ptr_q) + 1'b1)
    else $error("pointer did not advance");
  a_slot_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> vld_q[$past(slot)]) else $error("written entry not marked");
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_vld_q && !out_load |=> st_vld_q && $stable(st_smp_q))
    else $error("stalled stage lost its item");
`endif

endmodule

>>> bench/flanger_checker.sv
// result checker for the swept delay flanger: predicts each output sample and compares
`timescale 1ns / 1ps

module flanger_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  sdf_pkg::gain_t   cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  sdf_pkg::sample_t sample_in_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  sdf_pkg::sample_t sample_out_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  localparam int unsigned SPAN  = 80;
  localparam int unsigned STEPS = 8000;
  localparam int unsigned REPORT_MAX = 10;

  // shadow copy of the block state
  sdf_pkg::sample_t echo_line [0:SPAN];
  int unsigned      tap_ptr;
  int unsigned      lfo_step;
  sdf_pkg::gain_t   mix_gain;

  sdf_pkg::sample_t flange_queue [$];

  // 1 - cos of the lfo angle in q30, scaled to a delay in samples
  function automatic int unsigned sweep_depth(input int unsigned phase);
    longint unsigned steps, pp, m, mm, x, x2, term, v;
    longint          sum, omc;
    bit              flip;
    steps = STEPS;
    pp    = phase % steps;
    if (pp > steps - pp) pp = steps - pp;
    m = 2 * pp;
    if (m == 0)                omc = 0;
    else if (3 * m == steps)   omc = sdf_pkg::ONE_Q30 / 2;
    else if (2 * m == steps)   omc = sdf_pkg::ONE_Q30;
    else if (3 * m == 2 * steps) omc = 3 * (sdf_pkg::ONE_Q30 / 2);
    else if (m == steps)       omc = 2 * sdf_pkg::ONE_Q30;
    else begin
      flip = (2 * m > steps);
      mm   = flip ? (steps - m) : m;
      x    = (sdf_pkg::PI_Q30 * mm + steps / 2) / steps;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = sdf_pkg::ONE_Q30;
      sum  = sdf_pkg::ONE_Q30;
      for (int unsigned k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
        if (k & 1) sum = sum - longint'(term);
        else       sum = sum + longint'(term);
      end
      omc = flip ? (sdf_pkg::ONE_Q30 + sum) : (sdf_pkg::ONE_Q30 - sum);
    end
    if (omc < 0)                    omc = 0;
    if (omc > 2 * sdf_pkg::ONE_Q30) omc = 2 * sdf_pkg::ONE_Q30;
    v = (longint'(SPAN) * omc) >> 31;
    if (v > SPAN) v = SPAN;
    return int'(v);
  endfunction

  // one sample through the shadow flanger
  function automatic sdf_pkg::sample_t flange_sample(input sdf_pkg::sample_t dry);
    int unsigned depth, slot;
    longint      prod, scaled, wet;
    depth  = sweep_depth(lfo_step);
    prod   = longint'($unsigned(mix_gain)) * longint'(echo_line[tap_ptr]);
    scaled = (prod + (64'sd1 <<< 14)) >>> 15;
    wet    = longint'(dry) + scaled;
    if (wet > 32767)  wet = 32767;
    if (wet < -32768) wet = -32768;
    slot = (tap_ptr >= depth) ? (tap_ptr - depth) : (tap_ptr + SPAN + 1 - depth);
    echo_line[slot] = dry;
    if (tap_ptr == SPAN) begin
      tap_ptr = 0;
      lfo_step = (lfo_step == STEPS - 1) ? 0 : lfo_step + 1;
    end else begin
      tap_ptr = tap_ptr + 1;
    end
    return sdf_pkg::sample_t'(wet[15:0]);
  endfunction

  always @(posedge clk_i) begin
    sdf_pkg::sample_t want;
    if (!rst_ni) begin
      foreach (echo_line[i]) echo_line[i] = '0;
      tap_ptr      = 0;
      lfo_step     = 0;
      mix_gain     = sdf_pkg::GAIN_RESET;
      flange_queue.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) mix_gain = cfg_wdata_i;
      if (in_valid_i && in_ready_i) flange_queue.push_back(flange_sample(sample_in_i));
      if (out_valid_i && out_ready_i) begin
        if (flange_queue.size() == 0) begin
          if (fail_count_o < REPORT_MAX)
            $display("unexpected output sample %0d with nothing pending", sample_out_i);
          fail_count_o++;
        end else begin
          want = flange_queue.pop_front();
          if (sample_out_i !== want) begin
            if (fail_count_o < REPORT_MAX)
              $display("sample %0d mismatch: expected %0d, got %0d",
                       checked_o, want, sample_out_i);
            fail_count_o++;
          end
          checked_o++;
        end
      end
      pending_o = flange_queue.size();
    end
  end

endmodule

>>> bench/testbench.sv
// testbench top for the swept delay flanger: stimulus, output back-pressure and verdict
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;
  // long receiver hold-off, enough to fill every internal stage
  localparam int unsigned HOLD_CYCLES = 300;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  sdf_pkg::gain_t   cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  sdf_pkg::sample_t sample_in_i;
  logic             out_valid_o;
  logic             out_ready_i;
  sdf_pkg::sample_t sample_out_o;

  int fail_count;
  int pending;
  int checked;

  int          cycle_count = 0;
  int          items_sent  = 0;
  int          gain_settings = 1;
  int          burst_left  = 0;
  bit          hold_armed  = 1'b0;
  bit          hold_done   = 1'b0;

  always #6 clk_i = ~clk_i;

  swept_delay_flanger dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

  flanger_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_i (sample_out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still pending", cycle_count, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: one long hold-off when armed, otherwise a random stall pattern in windows
  initial begin
    int unsigned window_left;
    int unsigned mode;
    out_ready_i = 1'b0;
    window_left = 0;
    mode        = 0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && !hold_done) begin
        // output held off while the sender keeps pushing, the block backs up
        out_ready_i = 1'b0;
        for (int unsigned n = 1; n < HOLD_CYCLES; n++) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (window_left == 0) begin
          window_left = $urandom_range(8, 64);
          mode        = $urandom_range(0, 3);
        end
        window_left--;
        case (mode)
          0: out_ready_i = 1'b1;                        // no stalls
          1: out_ready_i = ($urandom_range(0, 3) != 0); // light stalls
          2: out_ready_i = ($urandom_range(0, 3) == 0); // heavy stalls
          default: out_ready_i = ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // mostly full-range samples, with rails and small values to stress saturation
  function automatic sdf_pkg::sample_t pick_sample();
    case ($urandom_range(0, 15))
      0, 1:    return sdf_pkg::sample_t'(16'sh7fff);
      2, 3:    return sdf_pkg::sample_t'(16'sh8000);
      4:       return sdf_pkg::sample_t'($urandom_range(0, 15) - 8);
      default: return sdf_pkg::sample_t'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // one input transfer, entered and left at a falling edge
  task automatic send_sample(input sdf_pkg::sample_t value);
    in_valid_i  = 1'b1;
    sample_in_i = value;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
    // bursts of back-to-back transfers with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_sample(pick_sample());
  endtask

  // sender pauses until every predicted sample has come out
  task automatic drain();
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  // gain register write, only with the block idle
  task automatic set_gain(input sdf_pkg::gain_t value);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    gain_settings++;
  endtask

  initial begin
    sdf_pkg::sample_t directed [$];
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: rails, zero, unit steps and alternating bit patterns at the reset gain;
    // these land in the delay store and come back scaled one lap later
    directed = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                 16'sh4000, 16'shc000, 16'sh5555, 16'shaaaa, 16'sh7ffe,
                 16'sh8001, 16'sh0100, 16'shff00, 16'sh7fff, 16'sh7fff,
                 16'sh8000, 16'sh8000, 16'sh00ff, 16'sh3fff, 16'shc001};
    foreach (directed[i]) send_sample(directed[i]);
    run_random(200);
    drain();

    // full-scale gain with the long output hold-off, saturation on both rails
    set_gain(15'h7fff);
    hold_armed = 1'b1;
    run_random(300);
    drain();

    // zero gain, output is the dry sample
    set_gain(15'h0000);
    run_random(200);
    drain();

    // half gain, exercises round-half-up on odd delayed samples
    set_gain(15'h4000);
    run_random(200);
    drain();

    // smallest nonzero gain
    set_gain(15'h0001);
    run_random(150);
    drain();

    // some random gain in between
    set_gain(sdf_pkg::gain_t'($urandom_range(2, 32766)));
    run_random(300);
    drain();

    // let the pipeline settle past its latency
    repeat (8) @(negedge clk_i);

    $display("%0d samples sent and %0d checked over %0d gain settings,", items_sent,
             checked, gain_settings);
    $display("with burst gaps, random output stalls, one long hold-off and drained pauses");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d samples left over", fail_count, pending);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sdf_pkg.sv
hw/rtl/sdf_ram.sv
hw/rtl/sdf_sweep.sv
hw/rtl/swept_delay_flanger.sv
bench/flanger_checker.sv
bench/testbench.sv
